// ===== rtl/core/template_bit_pack_unpack_top_macros.svh =====
// Assertion macros used by the template bit pack / unpack back end
`ifndef TEMPLATE_BIT_PACK_UNPACK_TOP_MACROS_SVH
`define TEMPLATE_BIT_PACK_UNPACK_TOP_MACROS_SVH

// Property that must hold on every clock edge out of reset
`define TBPU_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Implication checked on every clock edge out of reset
`define TBPU_ASSERT_IMP(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) else $error(msg);

`endif

// ===== rtl/core/tbpu_pkg.sv =====
// Shared types and constants for the template bit pack / unpack block
`timescale 1ns / 1ps
package tbpu_pkg;

  // Configuration register indexes
  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_LENGTH    = 1'b1;

  // Input operation codes
  localparam logic OP_TEMPLATE = 1'b0;
  localparam logic OP_DATA     = 1'b1;

  localparam int MaxResults = 64;

  typedef enum logic {
    KIND_WRITE,
    KIND_DATA
  } kind_e;

  // One classified request between front and back
  typedef struct packed {
    kind_e      kind;
    logic [9:0] idx;
    logic [7:0] val;
  } req_t;

endpackage

// ===== rtl/core/template_bit_pack_unpack_top.sv =====
// Top level of the template bit pack / unpack block
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid / tready    tuser operation, tdata index and value
//  m_axis    out  tvalid / tready    tdata out_byte, tlast block_end
//  cfg       in   cfg_we_i           cfg_index_i, cfg_data_i
//
// A template write is stored as it is accepted, and the back end stays idle. A compress
// byte goes through accept, memory read, extract, then one step per packed byte and a
// return to idle. An expand byte goes through accept, then per template byte reached a
// memory read and a mask load (an empty byte is emitted as a zero byte), one deposit
// step per bit, and a final step to see the input bits are used up.
// The template read is registered and each deposit step places one bit;
// every output byte also waits while the output register is still held.
// Reset clears control and progress; the template memory is not cleared.
// A two-entry queue lets the input side keep going while the output stalls.
`timescale 1ns / 1ps
module template_bit_pack_unpack_top
  import tbpu_pkg::*;
#(
  parameter int TEMPLATE_MAX = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // template_index [9:0], value [17:10], zero pad
  input  logic        s_axis_tuser_i,  // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  logic q_valid, q_ready;
  req_t q_req;

  tbpu_front #(.TEMPLATE_MAX(TEMPLATE_MAX)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_op_i    (s_axis_tuser_i),
    .s_idx_i   (s_axis_tdata_i[9:0]),
    .s_val_i   (s_axis_tdata_i[17:10]),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_req_o   (q_req)
  );

  tbpu_back #(.TEMPLATE_MAX(TEMPLATE_MAX)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_req_i     (q_req),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_byte_o    (m_axis_tdata_o),
    .m_last_o    (m_axis_tlast_o)
  );

endmodule

// ===== rtl/core/tbpu_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end
`timescale 1ns / 1ps
module tbpu_front
  import tbpu_pkg::*;
#(
  parameter int TEMPLATE_MAX = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic        s_op_i,
  input  logic [9:0]  s_idx_i,
  input  logic [7:0]  s_val_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output req_t        q_req_o
);

  req_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, keep, push, pop;
  req_t       req;

  // Classify: out-of-range template writes are dropped here
  always_comb begin
    req.kind = (s_op_i == OP_DATA) ? KIND_DATA : KIND_WRITE;
    req.idx  = s_idx_i;
    req.val  = s_val_i;
    keep     = (s_op_i == OP_DATA) || (32'(s_idx_i) < 32'(TEMPLATE_MAX));
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign accept    = s_valid_i && s_ready_o;
  assign push      = accept && keep;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_req_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  // Two-entry queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= req;
    end
  end

endmodule

// ===== rtl/core/tbpu_back.sv =====
// Back end: template memory, bit extract / deposit sequencer and output register
`timescale 1ns / 1ps
module tbpu_back
  import tbpu_pkg::*;
#(
  parameter int TEMPLATE_MAX = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  req_t        q_req_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [7:0]  m_byte_o,
  output logic        m_last_o
);

  localparam int AW = (TEMPLATE_MAX > 1) ? $clog2(TEMPLATE_MAX) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_EXP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [7:0]  mem [TEMPLATE_MAX];
  logic [7:0]  rdata_q;

  logic [2:0]  state_q, state_d;
  logic        dir_q;
  logic [10:0] len_q;
  logic [10:0] pos_q, pos_d;
  logic [15:0] buf_q, buf_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [7:0]  mask_q, mask_d;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  v_q, v_d;
  logic [3:0]  left_q, left_d;
  logic [6:0]  n_q, n_d;
  logic        p0v_q, p0v_d, p1v_q, p1v_d;
  logic [7:0]  p0b_q, p0b_d, p1b_q, p1b_d;
  logic        ov_q;
  logic [7:0]  ob_q;
  logic        ol_q;

  logic [12:0] eff_len;
  logic [10:0] pos_inc;
  logic        blk_end;
  logic        slot_free;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        mem_we;

  // Effective block length, clamped to 1 .. TEMPLATE_MAX
  always_comb begin
    if (len_q == 11'd0) begin
      eff_len = 13'd1;
    end else if ({2'b00, len_q} > 13'(TEMPLATE_MAX)) begin
      eff_len = 13'(TEMPLATE_MAX);
    end else begin
      eff_len = {2'b00, len_q};
    end
    pos_inc = pos_q + 11'd1;
    blk_end = ({2'b00, pos_inc} >= eff_len);
  end

  assign slot_free = !ov_q || m_ready_i;
  assign q_ready_o = (state_q == S_IDLE) && !cfg_we_i;
  assign mem_we    = q_valid_i && q_ready_o && (q_req_i.kind == KIND_WRITE);

  // Template memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(q_req_i.idx)] <= q_req_i.val;
    end
    if (state_q == S_RD) begin
      rdata_q <= mem[AW'(pos_q)];
    end
  end

  // Sequencer
  always_comb begin
    logic [7:0]  r;
    logic [3:0]  k;
    logic [3:0]  bc;
    logic [15:0] bn;
    logic [4:0]  cn;
    logic [7:0]  t;
    logic [7:0]  low;
    logic [7:0]  mn;
    logic [7:0]  byn;
    state_d   = state_q;
    pos_d     = pos_q;
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    mask_d    = mask_q;
    byte_d    = byte_q;
    v_d       = v_q;
    left_d    = left_q;
    n_d       = n_q;
    p0v_d     = p0v_q;
    p0b_d     = p0b_q;
    p1v_d     = p1v_q;
    p1b_d     = p1b_q;
    emit      = 1'b0;
    emit_byte = 8'd0;
    emit_last = 1'b0;
    r         = 8'd0;
    k         = 4'd0;
    bc        = 4'd0;
    bn        = 16'd0;
    cn        = 5'd0;
    t         = rdata_q;
    low       = mask_q & (~mask_q + 8'd1);
    mn        = mask_q & ~low;
    byn       = v_q[0] ? (byte_q | low) : byte_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && q_ready_o && (q_req_i.kind == KIND_DATA)) begin
          v_d     = q_req_i.val;
          left_d  = 4'd8;
          n_d     = 7'd0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = dir_q ? S_EXP : S_CMP;
      end
      S_CMP: begin
        // parallel bit extract of the data byte under the template
        for (int i = 0; i < 8; i++) begin
          if (t[i]) begin
            r[k[2:0]] = v_q[i];
            k         = k + 4'd1;
          end
        end
        bc = (cnt_q > 5'd8) ? 4'd8 : cnt_q[3:0];
        bn = buf_q | (16'(r) << bc);
        cn = 5'(bc) + 5'(k);
        p0v_d = 1'b0;
        p1v_d = 1'b0;
        if (cn > 5'd8) begin
          p0v_d = 1'b1;
          p0b_d = bn[7:0];
          bn    = bn >> 8;
          cn    = cn - 5'd8;
        end
        if (blk_end) begin
          pos_d = 11'd0;
          p1v_d = (cn != 5'd0);
          p1b_d = bn[7:0];
          bn    = 16'd0;
          cn    = 5'd0;
        end else begin
          pos_d = pos_inc;
        end
        buf_d   = bn;
        cnt_d   = cn;
        state_d = S_OUT;
      end
      S_EXP: begin
        // one deposit step per cycle; a step that emits a byte is held while the output register is full
        if (n_q == 7'(MaxResults)) begin
          state_d = S_IDLE;
        end else if (mask_q == 8'd0) begin
          if (t == 8'd0) begin
            emit      = 1'b1;
            emit_byte = 8'd0;
            emit_last = blk_end;
            if (slot_free) begin
              byte_d  = 8'd0;
              n_d     = n_q + 7'd1;
              pos_d   = blk_end ? 11'd0 : pos_inc;
              state_d = blk_end ? S_IDLE : S_RD;
            end
          end else if (left_q == 4'd0) begin
            state_d = S_IDLE;
          end else begin
            mask_d = t;
          end
        end else if (left_q == 4'd0) begin
          state_d = S_IDLE;
        end else if (mn == 8'd0) begin
          emit      = 1'b1;
          emit_byte = byn;
          emit_last = blk_end;
          if (slot_free) begin
            mask_d  = 8'd0;
            byte_d  = 8'd0;
            v_d     = v_q >> 1;
            left_d  = left_q - 4'd1;
            n_d     = n_q + 7'd1;
            pos_d   = blk_end ? 11'd0 : pos_inc;
            state_d = blk_end ? S_IDLE : S_RD;
          end
        end else begin
          mask_d = mn;
          byte_d = byn;
          v_d    = v_q >> 1;
          left_d = left_q - 4'd1;
        end
      end
      S_OUT: begin
        // drain up to two packed bytes
        if (p0v_q) begin
          emit      = 1'b1;
          emit_byte = p0b_q;
          if (slot_free) begin
            p0v_d = 1'b0;
          end
        end else if (p1v_q) begin
          emit      = 1'b1;
          emit_byte = p1b_q;
          emit_last = 1'b1;
          if (slot_free) begin
            p1v_d = 1'b0;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and progress registers; a config write clears progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dir_q   <= 1'b0;
      len_q   <= 11'd1;
      pos_q   <= 11'd0;
      buf_q   <= 16'd0;
      cnt_q   <= 5'd0;
      mask_q  <= 8'd0;
      byte_q  <= 8'd0;
      p0v_q   <= 1'b0;
      p1v_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_DIRECTION) begin
          dir_q <= cfg_data_i[0];
        end else begin
          len_q <= cfg_data_i;
        end
        pos_q  <= 11'd0;
        buf_q  <= 16'd0;
        cnt_q  <= 5'd0;
        mask_q <= 8'd0;
        byte_q <= 8'd0;
      end else begin
        pos_q  <= pos_d;
        buf_q  <= buf_d;
        cnt_q  <= cnt_d;
        mask_q <= mask_d;
        byte_q <= byte_d;
      end
      state_q <= state_d;
      p0v_q   <= p0v_d;
      p1v_q   <= p1v_d;
      if (emit && slot_free) begin
        ov_q <= 1'b1;
      end else if (m_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    v_d_reg: begin
      v_q    <= v_d;
      left_q <= left_d;
      n_q    <= n_d;
      p0b_q  <= p0b_d;
      p1b_q  <= p1b_d;
    end
    if (emit && slot_free) begin
      ob_q <= emit_byte;
      ol_q <= emit_last;
    end
  end

  assign m_valid_o = ov_q;
  assign m_byte_o  = ob_q;
  assign m_last_o  = ol_q;

`include "template_bit_pack_unpack_top_macros.svh"

  `TBPU_ASSERT(a_pos_in_block, {2'b00, pos_q} < eff_len, "block position beyond length")
  `TBPU_ASSERT(a_cnt_range, cnt_q <= 5'd8, "packed bit count above one byte")
  `TBPU_ASSERT(a_byte_mask, (byte_q & mask_q) == 8'd0, "deposit byte overlaps pending bits")
  `TBPU_ASSERT_IMP(a_emit_slot, emit && slot_free, ##1 m_valid_o, "emitted byte not shown")

endmodule

// ===== dv/template_bit_pack_unpack_top_test.sv =====
// Self-checking testbench for the template bit pack / unpack block
`timescale 1ns / 1ps
module template_bit_pack_unpack_top_test;
  import tbpu_pkg::*;

  localparam int TmplDepth  = 1024;
  localparam int TmplSpan   = 80;
  localparam int CycleLimit = 400000;
  localparam int SettleCyc  = 200;

  typedef struct packed {
    logic       op;
    logic [9:0] idx;
    logic [7:0] val;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [10:0] cfg_data_i;

  request_t  pending_q[$];
  out_byte_t expected_q[$];
  int        send_idle_pct;
  int        recv_stall_pct;
  int        mismatches;
  int        bytes_checked;
  int        requests_sent;
  int        cycles = 0;

  // Shadow copy of the block state
  logic [7:0]  tmpl_mem [TmplDepth];
  logic        mode_expand;
  logic [10:0] tmpl_len;
  int unsigned blk_pos, pack_buf, pack_cnt, mask_left, deposit_byte;

  template_bit_pack_unpack_top i_dut (.*);

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned block_len();
    if (tmpl_len == 0) return 1;
    if (tmpl_len > TmplDepth) return TmplDepth;
    return tmpl_len;
  endfunction

  // true when the block just ended
  function automatic bit step_pos();
    blk_pos = (blk_pos + 1) & 'h7ff;
    if (blk_pos >= block_len()) begin
      blk_pos = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_byte(int unsigned b, bit last);
    out_byte_t o;
    o.data = b[7:0];
    o.last = last;
    expected_q.push_back(o);
  endfunction

  function automatic void extract_bits(logic [7:0] v);
    int unsigned t, r, k;
    r = 0;
    k = 0;
    if (blk_pos >= block_len()) blk_pos = 0;
    t = tmpl_mem[blk_pos];
    for (int i = 0; i < 8; i++) begin
      if (t[i]) begin
        r |= v[i] << k;
        k++;
      end
    end
    if (pack_cnt > 8) pack_cnt = 8;
    pack_buf = (pack_buf | (r << pack_cnt)) & 'hffff;
    pack_cnt += k;
    if (pack_cnt > 8) begin
      add_byte(pack_buf, 1'b0);
      pack_buf >>= 8;
      pack_cnt -= 8;
    end
    if (step_pos()) begin
      if (pack_cnt > 0) add_byte(pack_buf, 1'b1);
      pack_buf = 0;
      pack_cnt = 0;
    end
  endfunction

  function automatic void deposit_bits(logic [7:0] val);
    int unsigned n, bits_left, low, t, v;
    bit fin;
    n = 0;
    bits_left = 8;
    v = val;
    if (blk_pos >= block_len()) blk_pos = 0;
    while (n < MaxResults) begin
      if (mask_left == 0) begin
        t = tmpl_mem[blk_pos];
        if (t == 0) begin
          fin = step_pos();
          add_byte(0, fin);
          n++;
          deposit_byte = 0;
          if (fin) break;
          continue;
        end
        if (bits_left == 0) break;
        mask_left = t;
      end
      if (bits_left == 0) break;
      low = mask_left & (0 - mask_left) & 'hff;
      if (v & 1) deposit_byte |= low;
      v >>= 1;
      bits_left--;
      mask_left &= ~low & 'hff;
      if (mask_left == 0) begin
        fin = step_pos();
        add_byte(deposit_byte, fin);
        n++;
        deposit_byte = 0;
        if (fin) break;
      end
    end
  endfunction

  function automatic void predict(request_t r);
    if (r.op == OP_TEMPLATE) tmpl_mem[r.idx] = r.val;
    else if (mode_expand) deposit_bits(r.val);
    else extract_bits(r.val);
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    request_t r;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        r = pending_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {6'd0, r.val, r.idx};
        s_axis_tuser_i  <= r.op;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on accepted requests, check accepted output bytes
  always @(posedge clk_i) begin
    request_t  r;
    out_byte_t e;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        r.op  = s_axis_tuser_i;
        r.idx = s_axis_tdata_i[9:0];
        r.val = s_axis_tdata_i[17:10];
        predict(r);
        requests_sent++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        bytes_checked++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected byte %02h last %0b", m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          e = expected_q.pop_front();
          if (e.data !== m_axis_tdata_o || e.last !== m_axis_tlast_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("byte mismatch: exp %02h last %0b, got %02h last %0b",
                       e.data, e.last, m_axis_tdata_o, m_axis_tlast_o);
          end
        end
      end
    end
  end

  task automatic push_req(logic op, logic [9:0] idx, logic [7:0] val);
    request_t r;
    r.op  = op;
    r.idx = idx;
    r.val = val;
    pending_q.push_back(r);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || s_axis_tvalid_i || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Register write while idle; progress is cleared on every write
  task automatic write_reg(logic idx, logic [10:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DIRECTION) mode_expand = data[0];
    else tmpl_len = data;
    blk_pos = 0;
    pack_buf = 0;
    pack_cnt = 0;
    mask_left = 0;
    deposit_byte = 0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_tmpl();
    case ($urandom_range(7))
      0, 1: return 8'h00;
      2:    return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [10:0] lens [8];
    int          n_items;
    mismatches = 0;
    bytes_checked = 0;
    requests_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_DIRECTION;
    cfg_data_i = '0;
    mode_expand = 1'b0;
    tmpl_len = 11'd1;
    blk_pos = 0;
    pack_buf = 0;
    pack_cnt = 0;
    mask_left = 0;
    deposit_byte = 0;
    lens = '{11'd0, 11'd1, 11'd3, 11'd7, 11'd16, 11'd80, 11'd32, 11'd5};
    @(posedge rst_ni);
    @(posedge clk_i);

    // Zero every template entry a block can reach, so none is read unwritten
    for (int i = 0; i < TmplSpan; i++) push_req(OP_TEMPLATE, 10'(i), 8'h00);
    drain();

    // Directed: expand, all-zero template over a long block hits result cap
    write_reg(CFG_DIRECTION, 11'd1);
    write_reg(CFG_LENGTH, 11'(TmplSpan));
    push_req(OP_DATA, 10'd0, 8'hff);
    push_req(OP_DATA, 10'd0, 8'h01);
    drain();

    // Directed: compress, single-byte block
    write_reg(CFG_DIRECTION, 11'd0);
    write_reg(CFG_LENGTH, 11'd1);
    push_req(OP_TEMPLATE, 10'd0, 8'hff);
    push_req(OP_DATA, 10'd0, 8'h00);
    push_req(OP_DATA, 10'd0, 8'hff);
    push_req(OP_DATA, 10'd1023, 8'ha5);
    push_req(OP_TEMPLATE, 10'd0, 8'h00);   // empty template: no output
    push_req(OP_DATA, 10'd0, 8'h3c);
    push_req(OP_TEMPLATE, 10'd0, 8'h81);   // dropped bits outside template
    push_req(OP_DATA, 10'd0, 8'h7e);
    push_req(OP_DATA, 10'd0, 8'h81);
    drain();
    // Directed: expand across an empty template byte
    write_reg(CFG_DIRECTION, 11'd1);
    write_reg(CFG_LENGTH, 11'd3);
    push_req(OP_TEMPLATE, 10'd0, 8'h0f);
    push_req(OP_TEMPLATE, 10'd1, 8'h00);
    push_req(OP_TEMPLATE, 10'd2, 8'hf0);
    push_req(OP_DATA, 10'd0, 8'hff);
    push_req(OP_DATA, 10'd0, 8'h5a);
    push_req(OP_DATA, 10'd0, 8'h00);
    push_req(OP_TEMPLATE, 10'd3, 8'h00);
    drain();
    for (int i = 0; i < 32; i++) push_req(OP_TEMPLATE, 10'(i), rand_tmpl());
    drain();

    // Random phases over both directions and several block lengths
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      write_reg(CFG_DIRECTION, 11'(ph[0]));
      write_reg(CFG_LENGTH, lens[(ph / 2) % 8]);
      n_items = 8;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(99) < 15)
          push_req(OP_TEMPLATE, 10'($urandom_range(15)), rand_tmpl());
        else push_req(OP_DATA, 10'($urandom_range(1023)), 8'($urandom_range(255)));
        // hold off once mid-phase until every expected byte is back
        if (ph == 5 && i == n_items / 2) begin
          while (pending_q.size() != 0 || s_axis_tvalid_i || expected_q.size() != 0)
            @(posedge clk_i);
        end
      end
      drain();
    end

    $display("Requests accepted: %0d, output bytes checked: %0d", requests_sent,
             bytes_checked);
    $display("Covered compress and expand, block lengths 0 to 80, result cap, idle and stall mixes");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
